/* src/pboe_pkg.sv */
// shared types, constants and edge helpers for the pairwise box overlap engine
package pboe_pkg;

  parameter int unsigned CmdW     = 2;
  parameter int unsigned InDataW  = 88;
  parameter int unsigned OutDataW = 24;

  // command codes carried in the slave tuser
  typedef enum logic [CmdW-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_RUN    = 2'd2
  } cmd_e;

  // doubled-unit edge coordinate: 2*centre +/- size
  typedef logic signed [18:0] coord_t;

  // one stored entry, tag in the lowest bits to match the input word
  typedef struct packed {
    logic [15:0]        mask;
    logic [15:0]        height;
    logic [15:0]        width;
    logic signed [15:0] cy;
    logic signed [15:0] cx;
    logic [7:0]         tag;
  } entry_t;

  // entry as edges, ready for comparison
  typedef struct packed {
    logic [7:0]  tag;
    logic [15:0] mask;
    coord_t      lo_x;
    coord_t      hi_x;
    coord_t      lo_y;
    coord_t      hi_y;
  } box_t;

  // result word, first_tag in the lowest bits
  typedef struct packed {
    logic [3:0] second_sides;
    logic [3:0] first_sides;
    logic [7:0] second_tag;
    logic [7:0] first_tag;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic take;      // input word accepted this cycle
    logic we;        // table write
    logic wsel_in;   // write data from input word, else from read register
    logic rd_en;     // table read into read register
    logic rd_pair;   // the read is the later box of a pair
    logic load_a;    // read register becomes the earlier box
    logic emit_end;  // load the run terminator into the output register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic s1_free;    // read register may be overwritten this cycle
    logic pair_pend;  // a pair waits in the read register
    logic out_free;   // output register can take a word this cycle
    logic tag_match;  // read register tag equals the remove tag
  } dp_stat_t;

  function automatic coord_t lo_side(logic signed [15:0] c, logic [15:0] s);
    return $signed({{2{c[15]}}, c, 1'b0}) - $signed({3'b000, s});
  endfunction

  function automatic coord_t hi_side(logic signed [15:0] c, logic [15:0] s);
    return $signed({{2{c[15]}}, c, 1'b0}) + $signed({3'b000, s});
  endfunction

  function automatic box_t to_box(entry_t e);
    box_t b;
    b.tag  = e.tag;
    b.mask = e.mask;
    b.lo_x = lo_side(e.cx, e.width);
    b.hi_x = hi_side(e.cx, e.width);
    b.lo_y = lo_side(e.cy, e.height);
    b.hi_y = hi_side(e.cy, e.height);
    return b;
  endfunction

endpackage

/* src/pboe_dp.sv */
// datapath: box table memory, earlier-box register, pair test and output register
module pboe_dp #(
  parameter int unsigned MAX_BOXES = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  pboe_pkg::dp_cmd_t                      cmd_i,
  input  logic [$clog2(MAX_BOXES)-1:0]           raddr_i,
  input  logic [$clog2(MAX_BOXES)-1:0]           waddr_i,
  input  logic [pboe_pkg::InDataW-1:0]           in_data_i,
  input  logic                                   out_ready_i,
  output pboe_pkg::dp_stat_t                     stat_o,
  output logic                                   out_valid_o,
  output logic [pboe_pkg::OutDataW-1:0]          out_data_o,
  output logic                                   out_last_o
);

  pboe_pkg::entry_t mem_q [MAX_BOXES];
  pboe_pkg::entry_t rdata_q;
  pboe_pkg::entry_t in_entry;
  pboe_pkg::entry_t wdata;
  pboe_pkg::box_t   a_q;
  pboe_pkg::box_t   b;
  pboe_pkg::res_t   res;
  pboe_pkg::res_t   out_data_q, out_data_d;
  logic [7:0]       rem_tag_q;
  logic             pair_v_q, pair_v_d;
  logic             out_valid_q, out_valid_d;
  logic             out_last_q, out_last_d;
  logic             out_free;
  logic             eval;
  logic             overlap;
  logic             hit;
  logic [3:0]       f1;

  assign in_entry = pboe_pkg::entry_t'(in_data_i);
  assign wdata    = cmd_i.wsel_in ? in_entry : rdata_q;

  // table storage, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem_q[waddr_i] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      rem_tag_q <= in_entry.tag;
    end
    if (cmd_i.load_a) begin
      a_q <= pboe_pkg::to_box(rdata_q);
    end
    out_data_q <= out_data_d;
  end

  // pair test against the later box in the read register
  assign b = pboe_pkg::to_box(rdata_q);
  assign overlap = ($signed(a_q.lo_x) < $signed(b.hi_x)) && ($signed(a_q.hi_x) > $signed(b.lo_x))
                && ($signed(a_q.lo_y) < $signed(b.hi_y)) && ($signed(a_q.hi_y) > $signed(b.lo_y));
  assign hit = overlap && (|(a_q.mask & b.mask));

  assign f1[0] = $signed(a_q.lo_x) < $signed(b.lo_x);
  assign f1[1] = $signed(a_q.hi_x) > $signed(b.hi_x);
  assign f1[2] = $signed(a_q.lo_y) < $signed(b.lo_y);
  assign f1[3] = $signed(a_q.hi_y) > $signed(b.hi_y);

  always_comb begin
    res.first_tag    = a_q.tag;
    res.second_tag   = b.tag;
    res.first_sides  = f1;
    res.second_sides = {f1[2], f1[3], f1[0], f1[1]};
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign eval     = pair_v_q && out_free;

  always_comb begin
    pair_v_d = pair_v_q;
    if (cmd_i.rd_en) begin
      pair_v_d = cmd_i.rd_pair;
    end else if (eval) begin
      pair_v_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_last_d  = out_last_q;
    out_data_d  = out_data_q;
    if (out_free) begin
      priority if (eval && hit) begin
        out_valid_d = 1'b1;
        out_last_d  = 1'b0;
        out_data_d  = res;
      end else if (cmd_i.emit_end) begin
        out_valid_d = 1'b1;
        out_last_d  = 1'b1;
        out_data_d  = '0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      pair_v_q    <= pair_v_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
    end
  end

  assign stat_o.s1_free   = !pair_v_q || out_free;
  assign stat_o.pair_pend = pair_v_q;
  assign stat_o.out_free  = out_free;
  assign stat_o.tag_match = (rdata_q.tag == rem_tag_q);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule

/* src/pboe_ctrl.sv */
// controller: command decode, table fill count, remove sweep and pair walk
module pboe_ctrl #(
  parameter int unsigned MAX_BOXES = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic [pboe_pkg::CmdW-1:0]            in_cmd_i,
  output logic                                 ready_o,
  input  pboe_pkg::dp_stat_t                   stat_i,
  output pboe_pkg::dp_cmd_t                    cmd_o,
  output logic [$clog2(MAX_BOXES)-1:0]         raddr_o,
  output logic [$clog2(MAX_BOXES)-1:0]         waddr_o
);

  localparam int unsigned IdxW = $clog2(MAX_BOXES);
  localparam int unsigned CntW = $clog2(MAX_BOXES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REM_RD,
    S_REM_WR,
    S_RUN_RDA,
    S_RUN_LDA,
    S_RUN_PAIR,
    S_RUN_END
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] i_q, i_d;
  logic [CntW-1:0] j_q, j_d;
  logic [CntW-1:0] r_q, r_d;
  logic [CntW-1:0] w_q, w_d;
  logic [CntW-1:0] w_next;
  logic [CntW-1:0] i_plus1;
  logic [CntW-1:0] i_plus2;
  logic            take;

  assign ready_o = (state_q == S_IDLE);
  assign take    = in_valid_i && ready_o;
  assign w_next  = w_q + (stat_i.tag_match ? CntW'(0) : CntW'(1));
  assign i_plus1 = i_q + CntW'(1);
  assign i_plus2 = i_q + CntW'(2);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    i_d     = i_q;
    j_d     = j_q;
    r_d     = r_q;
    w_d     = w_q;
    cmd_o   = '0;
    raddr_o = i_q[IdxW-1:0];
    waddr_o = count_q[IdxW-1:0];
    cmd_o.take = take;
    unique case (state_q)
      S_IDLE: begin
        if (take) begin
          unique case (in_cmd_i)
            pboe_pkg::CMD_ADD: begin
              if (count_q < CntW'(MAX_BOXES)) begin
                cmd_o.we      = 1'b1;
                cmd_o.wsel_in = 1'b1;
                count_d       = count_q + CntW'(1);
              end
            end
            pboe_pkg::CMD_REMOVE: begin
              r_d = '0;
              w_d = '0;
              if (count_q != '0) begin
                state_d = S_REM_RD;
              end
            end
            pboe_pkg::CMD_RUN: begin
              i_d = '0;
              if (count_q >= CntW'(2)) begin
                state_d = S_RUN_RDA;
              end else begin
                state_d = S_RUN_END;
              end
            end
            default: ;
          endcase
        end
      end
      S_REM_RD: begin
        cmd_o.rd_en = 1'b1;
        raddr_o     = r_q[IdxW-1:0];
        state_d     = S_REM_WR;
      end
      S_REM_WR: begin
        // keep entries whose tag differs, packed toward the front
        if (!stat_i.tag_match) begin
          cmd_o.we = 1'b1;
          waddr_o  = w_q[IdxW-1:0];
        end
        w_d = w_next;
        r_d = r_q + CntW'(1);
        if (r_q + CntW'(1) == count_q) begin
          count_d = w_next;
          state_d = S_IDLE;
        end else begin
          state_d = S_REM_RD;
        end
      end
      S_RUN_RDA: begin
        if (stat_i.s1_free) begin
          cmd_o.rd_en = 1'b1;
          raddr_o     = i_q[IdxW-1:0];
          state_d     = S_RUN_LDA;
        end
      end
      S_RUN_LDA: begin
        // earlier box captured, first later box read in the same cycle
        cmd_o.load_a  = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_pair = 1'b1;
        raddr_o       = i_plus1[IdxW-1:0];
        j_d           = i_plus2;
        if (i_plus2 == count_q) begin
          state_d = S_RUN_END;
        end else begin
          state_d = S_RUN_PAIR;
        end
      end
      S_RUN_PAIR: begin
        if (stat_i.s1_free) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_pair = 1'b1;
          raddr_o       = j_q[IdxW-1:0];
          j_d           = j_q + CntW'(1);
          if (j_q + CntW'(1) == count_q) begin
            i_d     = i_plus1;
            state_d = S_RUN_RDA;
          end
        end
      end
      S_RUN_END: begin
        if (!stat_i.pair_pend && stat_i.out_free) begin
          cmd_o.emit_end = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      i_q     <= '0;
      j_q     <= '0;
      r_q     <= '0;
      w_q     <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      i_q     <= i_d;
      j_q     <= j_d;
      r_q     <= r_d;
      w_q     <= w_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_BOXES))
    else $error("entry count beyond table depth");

  a_pair_read_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.rd_en && cmd_o.rd_pair) |-> stat_i.s1_free)
    else $error("pair read overwrites an untested pair");

  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_o |-> !stat_i.pair_pend)
    else $error("idle with a pair still pending");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN_PAIR) |-> ((j_q < count_q) && (i_plus1 < j_q)))
    else $error("pair walk out of range");
`endif

endmodule

/* src/pairwise_box_overlap_engine.sv */
// top level of the pairwise box overlap engine
//
// slave channel: one word per command, command code in tuser
//   add    : appends a box when the table has room, no result
//   remove : deletes every entry with the tag, keeps order, by a read then
//            write-back sweep over the stored entries, no result
//   run    : tests every pair i<j in table order; one result word per hit pair,
//            then one word with tlast high and zero data
// master channel: registered output word; a run walks about one pair per cycle
//   through the single table read port while the output is not stalled, with
//   an extra read state to load each earlier box
// a pair result passes through the read register, then the output register
// tready on the slave side is high only while no command is in progress
// a stalled master (tready low) freezes the pair walk once a pair waits behind
//   the held word; nothing is dropped, and a finished run end word waits while
//   the next command enters
// reset clears the entry count and output valid; table contents need no clear
module pairwise_box_overlap_engine #(
  parameter int unsigned MAX_BOXES = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // box_tag[7:0], center_x[23:8], center_y[39:24], box_width[55:40],
  // box_height[71:56], filter_mask[87:72]
  input  logic [pboe_pkg::InDataW-1:0]      s_axis_tdata,
  // command[1:0]
  input  logic [pboe_pkg::CmdW-1:0]         s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // first_tag[7:0], second_tag[15:8], first_sides[19:16], second_sides[23:20]
  output logic [pboe_pkg::OutDataW-1:0]     m_axis_tdata,
  // run_end
  output logic                              m_axis_tlast
);

  localparam int unsigned IdxW = $clog2(MAX_BOXES);

  pboe_pkg::dp_cmd_t  dp_cmd;
  pboe_pkg::dp_stat_t dp_stat;
  logic [IdxW-1:0]    raddr;
  logic [IdxW-1:0]    waddr;

  // sequencer for add, remove sweep and pair walk
  pboe_ctrl #(
    .MAX_BOXES (MAX_BOXES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .ready_o    (s_axis_tready),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd),
    .raddr_o    (raddr),
    .waddr_o    (waddr)
  );

  // table, edge compare and output word register
  pboe_dp #(
    .MAX_BOXES (MAX_BOXES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .raddr_i     (raddr),
    .waddr_i     (waddr),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .stat_o      (dp_stat),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

/* tb/tb_pairwise_box_overlap_engine.sv */
// testbench for the pairwise box overlap engine: directed rows, random commands, predictor
`timescale 1ns / 1ps

module tb_pairwise_box_overlap_engine;

  localparam int unsigned MaxBoxes  = 8;
  localparam int unsigned ItemGoal  = 400;
  localparam int unsigned StallMax  = 2000;  // cycles with no word moving on either side
  localparam int unsigned DrainWait = 60;    // a remove sweep of a full table fits well inside
  localparam logic [pboe_pkg::CmdW-1:0] CMD_SPARE = 2'd3;

  // bit positions of the side flags
  localparam int unsigned SIDE_RIGHT  = 0;
  localparam int unsigned SIDE_LEFT   = 1;
  localparam int unsigned SIDE_BOTTOM = 2;
  localparam int unsigned SIDE_TOP    = 3;

  typedef struct {
    logic [pboe_pkg::CmdW-1:0] code;
    pboe_pkg::entry_t          box;
    bit                        typed;     // expected run output written in the row
    bit                        has_pair;  // typed run reports one pair before its end word
    pboe_pkg::res_t            pair;
  } step_t;

  typedef struct {
    pboe_pkg::res_t word;
    logic           run_end;
  } hit_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [pboe_pkg::InDataW-1:0]  s_axis_tdata;
  logic [pboe_pkg::CmdW-1:0]     s_axis_tuser;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [pboe_pkg::OutDataW-1:0] m_axis_tdata;
  logic                          m_axis_tlast;

  pboe_pkg::entry_t boxes [MaxBoxes];
  int unsigned      box_count = 0;
  hit_t             hit_q [$];
  step_t            script [$];
  int unsigned      mismatches = 0;
  int unsigned      quiet_cycles = 0;
  bit               steady = 1'b0;
  pboe_pkg::res_t   seen;
  hit_t             want;

  pairwise_box_overlap_engine #(
    .MAX_BOXES(MaxBoxes)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic step_t mk(logic [pboe_pkg::CmdW-1:0] code, logic [7:0] tag,
                               logic [15:0] cx, logic [15:0] cy, logic [15:0] w,
                               logic [15:0] h, logic [15:0] mask, bit typed = 1'b0,
                               bit has_pair = 1'b0, pboe_pkg::res_t pair = '0);
    step_t st;
    st.code       = code;
    st.box.tag    = tag;
    st.box.cx     = cx;
    st.box.cy     = cy;
    st.box.width  = w;
    st.box.height = h;
    st.box.mask   = mask;
    st.typed      = typed;
    st.has_pair   = has_pair;
    st.pair       = pair;
    return st;
  endfunction

  // append one expected result word
  function automatic void book(hit_t h);
    hit_q.insert(hit_q.size(), h);
  endfunction

  // append one row to the directed script
  function automatic void add_row(step_t st);
    script.insert(script.size(), st);
  endfunction

  // mirror of the box table; a run queues one word per hit pair plus the end word
  task automatic apply_to_table(logic [pboe_pkg::CmdW-1:0] code, pboe_pkg::entry_t box);
    int unsigned kept;
    int          l1, r1, b1, t1, l2, r2, b2, t2;
    logic [3:0]  f1, f2;
    hit_t        hit;
    case (code)
      pboe_pkg::CMD_ADD: begin
        if (box_count < MaxBoxes) begin
          boxes[box_count] = box;
          box_count++;
        end
      end
      pboe_pkg::CMD_REMOVE: begin
        kept = 0;
        for (int r = 0; r < box_count; r++) begin
          if (boxes[r].tag != box.tag) begin
            boxes[kept] = boxes[r];
            kept++;
          end
        end
        box_count = kept;
      end
      pboe_pkg::CMD_RUN: begin
        for (int i = 0; i < box_count; i++) begin
          // edges in doubled units so halves stay exact
          l1 = 2 * int'($signed(boxes[i].cx)) - int'(boxes[i].width);
          r1 = 2 * int'($signed(boxes[i].cx)) + int'(boxes[i].width);
          b1 = 2 * int'($signed(boxes[i].cy)) - int'(boxes[i].height);
          t1 = 2 * int'($signed(boxes[i].cy)) + int'(boxes[i].height);
          for (int j = i + 1; j < box_count; j++) begin
            l2 = 2 * int'($signed(boxes[j].cx)) - int'(boxes[j].width);
            r2 = 2 * int'($signed(boxes[j].cx)) + int'(boxes[j].width);
            b2 = 2 * int'($signed(boxes[j].cy)) - int'(boxes[j].height);
            t2 = 2 * int'($signed(boxes[j].cy)) + int'(boxes[j].height);
            if ((boxes[i].mask & boxes[j].mask) != 16'h0000 &&
                l1 < r2 && r1 > l2 && b1 < t2 && t1 > b2) begin
              f1 = 4'h0;
              f2 = 4'h0;
              if (l1 < l2) begin
                f1[SIDE_RIGHT] = 1'b1;
                f2[SIDE_LEFT]  = 1'b1;
              end
              if (r1 > r2) begin
                f1[SIDE_LEFT]  = 1'b1;
                f2[SIDE_RIGHT] = 1'b1;
              end
              if (b1 < b2) begin
                f1[SIDE_BOTTOM] = 1'b1;
                f2[SIDE_TOP]    = 1'b1;
              end
              if (t1 > t2) begin
                f1[SIDE_TOP]    = 1'b1;
                f2[SIDE_BOTTOM] = 1'b1;
              end
              hit.word.first_tag    = boxes[i].tag;
              hit.word.second_tag   = boxes[j].tag;
              hit.word.first_sides  = f1;
              hit.word.second_sides = f2;
              hit.run_end           = 1'b0;
              book(hit);
            end
          end
        end
        book('{word: '0, run_end: 1'b1});
      end
      default: ;
    endcase
  endtask

  // present one command word, wait for the handshake, then book its results
  task automatic offer(step_t st);
    while (!steady && $urandom_range(99) < 36) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= st.box;
    s_axis_tuser  <= st.code;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (st.typed) begin
      if (st.has_pair) book('{word: st.pair, run_end: 1'b0});
      book('{word: '0, run_end: 1'b1});
    end else begin
      apply_to_table(st.code, st.box);
    end
  endtask

  // receiver stalls at random outside the steady stretch
  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 36);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen = m_axis_tdata;
      if (hit_q.size() == 0) begin
        $error("unexpected result word: first_tag %0d second_tag %0d run_end %0b",
               seen.first_tag, seen.second_tag, m_axis_tlast);
        mismatches++;
      end else begin
        want = hit_q.pop_front();
        if (seen.first_tag !== want.word.first_tag) begin
          $error("first_tag: expected %0d, got %0d", want.word.first_tag, seen.first_tag);
          mismatches++;
        end
        if (seen.second_tag !== want.word.second_tag) begin
          $error("second_tag: expected %0d, got %0d", want.word.second_tag, seen.second_tag);
          mismatches++;
        end
        if (seen.first_sides !== want.word.first_sides) begin
          $error("first_sides: expected %b, got %b", want.word.first_sides, seen.first_sides);
          mismatches++;
        end
        if (seen.second_sides !== want.word.second_sides) begin
          $error("second_sides: expected %b, got %b",
                 want.word.second_sides, seen.second_sides);
          mismatches++;
        end
        if (m_axis_tlast !== want.run_end) begin
          $error("run_end: expected %0b, got %0b", want.run_end, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallMax) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    step_t       st;
    int unsigned done_items;
    int unsigned pick;
    int unsigned shape;
    bit          held;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= pboe_pkg::CMD_ADD;

    // empty table, single box, identical pair, then back to empty
    add_row(mk(pboe_pkg::CMD_RUN, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    add_row(mk(pboe_pkg::CMD_ADD, 8'h01, 16'h0000, 16'h0000, 16'h000a, 16'h000a, 16'h0001));
    add_row(mk(pboe_pkg::CMD_RUN, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    add_row(mk(pboe_pkg::CMD_ADD, 8'h02, 16'h0000, 16'h0000, 16'h000a, 16'h000a, 16'h0001));
    add_row(mk(pboe_pkg::CMD_RUN, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1,
               1'b1, {4'h0, 4'h0, 8'h02, 8'h01}));
    add_row(mk(pboe_pkg::CMD_REMOVE, 8'h01, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    add_row(mk(pboe_pkg::CMD_REMOVE, 8'h02, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    add_row(mk(pboe_pkg::CMD_RUN, 8'hff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1));
    // corner boxes: extreme centres and sizes, touching edges, zero size, empty mask
    add_row(mk(pboe_pkg::CMD_ADD, 8'hff, 16'h8000, 16'h8000, 16'hffff, 16'hffff, 16'hffff));
    add_row(mk(pboe_pkg::CMD_ADD, 8'h00, 16'h7fff, 16'h7fff, 16'hffff, 16'hffff, 16'h8000));
    add_row(mk(pboe_pkg::CMD_ADD, 8'h80, 16'h0000, 16'h0000, 16'hffff, 16'hffff, 16'h0001));
    add_row(mk(pboe_pkg::CMD_ADD, 8'h7f, 16'h0064, 16'hff9c, 16'h001e, 16'h0032, 16'h8001));
    add_row(mk(pboe_pkg::CMD_ADD, 8'h55, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    add_row(mk(pboe_pkg::CMD_RUN, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    // remove of a tag not in the table, then the unused code
    add_row(mk(pboe_pkg::CMD_REMOVE, 8'h42, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    add_row(mk(CMD_SPARE, 8'h00, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    add_row(mk(pboe_pkg::CMD_RUN, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    // fill with a repeated tag, then one add past full
    add_row(mk(pboe_pkg::CMD_ADD, 8'h33, 16'h0005, 16'h0003, 16'h0040, 16'h0040, 16'h0101));
    add_row(mk(pboe_pkg::CMD_ADD, 8'h33, 16'hfff0, 16'h0010, 16'h0020, 16'h0008, 16'h0100));
    add_row(mk(pboe_pkg::CMD_ADD, 8'h33, 16'h0010, 16'hfff0, 16'h0008, 16'h0020, 16'hfffe));
    add_row(mk(pboe_pkg::CMD_ADD, 8'haa, 16'h0000, 16'h0000, 16'hffff, 16'hffff, 16'hffff));
    add_row(mk(pboe_pkg::CMD_RUN, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    add_row(mk(pboe_pkg::CMD_REMOVE, 8'h33, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    add_row(mk(pboe_pkg::CMD_RUN, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[k]) offer(script[k]);

    // the directed rows count toward the word total
    done_items = script.size();
    held       = 1'b0;
    while (done_items < ItemGoal) begin
      steady = (done_items >= 120 && done_items < 220);
      if (done_items == 250 && !held) begin
        // hold the sender off until every queued result is out
        held = 1'b1;
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (hit_q.size() != 0);
      end

      // payload: mostly a small cluster so boxes collide, some fully random
      shape = $urandom_range(99);
      if (shape < 10 && box_count > 0) begin
        st.box = boxes[$urandom_range(box_count - 1)];
        st.box.tag = 8'($urandom_range(7));
        st.box.cx  = st.box.cx + 16'($urandom_range(4)) - 16'd2;
        st.box.cy  = st.box.cy + 16'($urandom_range(4)) - 16'd2;
      end else if (shape < 30) begin
        st.box.tag    = 8'($urandom);
        st.box.cx     = 16'($urandom);
        st.box.cy     = 16'($urandom);
        st.box.width  = 16'($urandom);
        st.box.height = 16'($urandom);
        st.box.mask   = 16'($urandom);
      end else begin
        st.box.tag    = 8'($urandom_range(7));
        st.box.cx     = 16'($urandom_range(400)) - 16'd200;
        st.box.cy     = 16'($urandom_range(400)) - 16'd200;
        st.box.width  = 16'($urandom_range(300));
        st.box.height = 16'($urandom_range(300));
        st.box.mask   = (shape < 65) ?
                        (16'(1 << $urandom_range(15)) | 16'(1 << $urandom_range(15))) :
                        16'($urandom_range(15));
      end

      pick = $urandom_range(99);
      if (pick < 3) begin
        st.code = CMD_SPARE;
      end else if (box_count == MaxBoxes) begin
        st.code = (pick < 40) ? pboe_pkg::CMD_REMOVE :
                  (pick < 75) ? pboe_pkg::CMD_RUN : pboe_pkg::CMD_ADD;
      end else begin
        st.code = (pick < 50) ? pboe_pkg::CMD_ADD :
                  (pick < 70) ? pboe_pkg::CMD_REMOVE : pboe_pkg::CMD_RUN;
      end
      // removes mostly hit a stored tag
      if (st.code == pboe_pkg::CMD_REMOVE && box_count > 0 && $urandom_range(99) < 75) begin
        st.box.tag = boxes[$urandom_range(box_count - 1)].tag;
      end
      st.typed    = 1'b0;
      st.has_pair = 1'b0;
      st.pair     = '0;

      done_items++;
      offer(st);
    end

    steady = 1'b0;
    s_axis_tvalid <= 1'b0;
    while (hit_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
